// ===== design/buffer_pool_with_descriptor_ring_macros.svh =====
// Assertion macros for the buffer pool with descriptor ring.
`ifndef BUFFER_POOL_WITH_DESCRIPTOR_RING_MACROS_SVH
`define BUFFER_POOL_WITH_DESCRIPTOR_RING_MACROS_SVH

`ifndef ASSERT_OFF
`define BPRD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bprd assertion failed");
`define BPRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bprd assertion failed");
`else
`define BPRD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BPRD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== design/bprd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the buffer pool with descriptor ring.
package bprd_pkg;

   localparam int POOL_BUFFERS_DEFAULT = 64;
   localparam int RING_SLOTS_DEFAULT   = 16;
   localparam int BUFFER_BYTES         = 16;
   localparam int LENGTH_WIDTH         = 5;
   localparam int STATUS_WIDTH         = 3;

   typedef logic [LENGTH_WIDTH-1:0] length_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK,
      STATUS_RING_FULL,
      STATUS_POOL_EXHAUSTED,
      STATUS_RING_EMPTY,
      STATUS_TOO_LONG
   } status_type;

   typedef enum logic {
      CMD_PRODUCE,
      CMD_CONSUME
   } command_type;

   typedef enum logic [1:0] {
      STATE_INIT,
      STATE_IDLE,
      STATE_EXEC
   } state_type;

endpackage

// ===== design/bprd_req_if.sv =====
`timescale 1ns / 1ps
// Command channel: valid/ready with command and message length.
interface bprd_req_if;
   import bprd_pkg::*;

   logic        valid;
   logic        ready;
   command_type command;
   length_type  msg_length;

   modport source (output valid, output command, output msg_length, input ready);
   modport sink (input valid, input command, input msg_length, output ready);

endinterface

// ===== design/bprd_rsp_if.sv =====
`timescale 1ns / 1ps
// Result channel: valid/ready with status, buffer index and length.
interface bprd_rsp_if #(
   parameter int BUF_WIDTH = $clog2(bprd_pkg::POOL_BUFFERS_DEFAULT)
);
   import bprd_pkg::*;

   logic                 valid;
   logic                 ready;
   status_type           status;
   logic [BUF_WIDTH-1:0] buffer_index;
   length_type           out_length;

   modport source (output valid, output status, output buffer_index, output out_length,
                   input ready);
   modport sink (input valid, input status, input buffer_index, input out_length,
                 output ready);

endinterface

// ===== design/bprd_ram.sv =====
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM with registered read data.
module bprd_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8,
   localparam int ADDR_WIDTH = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  we,
   input  logic [ADDR_WIDTH-1:0] waddr,
   input  logic [WIDTH-1:0]      wdata,
   input  logic                  re,
   input  logic [ADDR_WIDTH-1:0] raddr,
   output logic [WIDTH-1:0]      rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/buffer_pool_with_descriptor_ring.sv =====
`timescale 1ns / 1ps
// Buffer pool with descriptor ring: free-list allocator feeding a descriptor FIFO.
// After reset the block builds the free list in the link memory, one entry per
// cycle; req_if.ready stays low during that pass. Afterwards each command passes
// through IDLE and EXEC: in IDLE the block issues the reads of the link memory
// (next free buffer) and the ring memory (descriptor at the read pointer), and in
// EXEC it uses the read data, writes back and loads the result register. The
// registered read of the link memory ahead of the head update is why a command
// needs both states. The result register lets a finished result wait while the
// next command is accepted; a command completes only once that register is free.
`include "buffer_pool_with_descriptor_ring_macros.svh"

module buffer_pool_with_descriptor_ring #(
   parameter int POOL_BUFFERS = bprd_pkg::POOL_BUFFERS_DEFAULT,
   parameter int RING_SLOTS   = bprd_pkg::RING_SLOTS_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   bprd_req_if.sink    req_if,
   bprd_rsp_if.source  rsp_if
);
   import bprd_pkg::*;

   localparam int BW      = $clog2(POOL_BUFFERS);
   localparam int RW      = $clog2(RING_SLOTS);
   localparam int RING_DW = LENGTH_WIDTH + BW;
   localparam logic [BW-1:0] LAST_BUFFER = BW'(POOL_BUFFERS - 1);
   localparam logic [RW-1:0] LAST_SLOT   = RW'(RING_SLOTS - 1);

   state_type   state_ff, state_in;
   logic [BW-1:0] init_ptr_ff, init_ptr_in;
   logic [BW-1:0] head_ff, head_in;
   logic [BW-1:0] tail_ff, tail_in;
   logic [RW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RW-1:0] wr_ptr_ff, wr_ptr_in;
   command_type cmd_ff, cmd_in;
   length_type  len_ff, len_in;
   status_type  status_ff, status_in;
   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff, rsp_status_in;
   logic [BW-1:0] rsp_index_ff, rsp_index_in;
   length_type  rsp_length_ff, rsp_length_in;

   logic [RW-1:0] rd_next, wr_next;
   status_type    check_status;
   logic          exec_go;

   logic          link_we, link_re;
   logic [BW-1:0] link_waddr, link_wdata, link_raddr, link_rdata;
   logic          ring_we, ring_re;
   logic [RW-1:0] ring_waddr, ring_raddr;
   logic [RING_DW-1:0] ring_wdata, ring_rdata;

   bprd_ram #(.DEPTH(POOL_BUFFERS), .WIDTH(BW)) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (link_waddr),
      .wdata (link_wdata),
      .re    (link_re),
      .raddr (link_raddr),
      .rdata (link_rdata)
   );

   bprd_ram #(.DEPTH(RING_SLOTS), .WIDTH(RING_DW)) u_ring_ram (
      .clock (clock),
      .we    (ring_we),
      .waddr (ring_waddr),
      .wdata (ring_wdata),
      .re    (ring_re),
      .raddr (ring_raddr),
      .rdata (ring_rdata)
   );

   assign rd_next = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
   assign wr_next = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
   assign exec_go = (state_ff == STATE_EXEC) && (!rsp_valid_ff || rsp_if.ready);

   always_comb begin
      if (req_if.command == CMD_PRODUCE) begin
         if (req_if.msg_length > length_type'(BUFFER_BYTES)) begin
            check_status = STATUS_TOO_LONG;
         end else if (wr_next == rd_ptr_ff) begin
            check_status = STATUS_RING_FULL;
         end else if (head_ff == tail_ff) begin
            check_status = STATUS_POOL_EXHAUSTED;
         end else begin
            check_status = STATUS_OK;
         end
      end else begin
         check_status = (rd_ptr_ff == wr_ptr_ff) ? STATUS_RING_EMPTY : STATUS_OK;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         STATE_INIT: begin
            if (init_ptr_ff == LAST_BUFFER) begin
               state_in = STATE_IDLE;
            end
         end
         STATE_IDLE: begin
            if (req_if.valid) begin
               state_in = STATE_EXEC;
            end
         end
         STATE_EXEC: begin
            if (exec_go) begin
               state_in = STATE_IDLE;
            end
         end
         default: state_in = STATE_INIT;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_if.ready  = (state_ff == STATE_IDLE);
      init_ptr_in   = init_ptr_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      cmd_in        = cmd_ff;
      len_in        = len_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_length_in = rsp_length_ff;
      link_we       = 1'b0;
      link_waddr    = tail_ff;
      link_wdata    = ring_rdata[BW-1:0];
      link_re       = 1'b0;
      link_raddr    = head_ff;
      ring_we       = 1'b0;
      ring_waddr    = wr_ptr_ff;
      ring_wdata    = {len_ff, head_ff};
      ring_re       = 1'b0;
      ring_raddr    = rd_ptr_ff;
      case (state_ff)
         STATE_INIT: begin
            link_we     = 1'b1;
            link_waddr  = init_ptr_ff;
            link_wdata  = (init_ptr_ff == LAST_BUFFER) ? '0 : init_ptr_ff + 1'b1;
            init_ptr_in = init_ptr_ff + 1'b1;
         end
         STATE_IDLE: begin
            if (req_if.valid) begin
               link_re   = 1'b1;
               ring_re   = 1'b1;
               cmd_in    = req_if.command;
               len_in    = req_if.msg_length;
               status_in = check_status;
            end
         end
         STATE_EXEC: begin
            if (exec_go) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_index_in  = '0;
               rsp_length_in = '0;
               if (status_ff == STATUS_OK) begin
                  if (cmd_ff == CMD_PRODUCE) begin
                     rsp_index_in = head_ff;
                     head_in      = link_rdata;
                     ring_we      = 1'b1;
                     wr_ptr_in    = wr_next;
                  end else begin
                     rsp_index_in  = ring_rdata[BW-1:0];
                     rsp_length_in = ring_rdata[RING_DW-1:BW];
                     link_we       = 1'b1;
                     tail_in       = ring_rdata[BW-1:0];
                     rd_ptr_in     = rd_next;
                  end
               end
            end
         end
         default: begin
            req_if.ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_INIT;
         init_ptr_ff  <= '0;
         head_ff      <= '0;
         tail_ff      <= LAST_BUFFER;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ptr_ff  <= init_ptr_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      len_ff        <= len_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_length_ff <= rsp_length_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = rsp_status_ff;
   assign rsp_if.buffer_index = rsp_index_ff;
   assign rsp_if.out_length   = rsp_length_ff;

   `BPRD_ASSERT_NEXT(a_accept_exec, clock, reset, req_if.valid && req_if.ready, state_ff == STATE_EXEC)
   `BPRD_ASSERT_IMPL(a_error_zero, clock, reset, rsp_if.valid && rsp_if.status != STATUS_OK, rsp_if.buffer_index == '0 && rsp_if.out_length == '0)
   `BPRD_ASSERT_IMPL(a_link_port, clock, reset, link_we, !link_re)
   `BPRD_ASSERT_IMPL(a_ring_ptrs, clock, reset, 1'b1, rd_ptr_ff <= LAST_SLOT && wr_ptr_ff <= LAST_SLOT)

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the buffer pool with descriptor ring.
package bprd_tb_pkg;
   import bprd_pkg::*;

   localparam int POOL_N = POOL_BUFFERS_DEFAULT;
   localparam int RING_N = RING_SLOTS_DEFAULT;
   localparam int IDX_W  = $clog2(POOL_N);
   localparam int SLOT_W = $clog2(RING_N);

   typedef struct {
      status_type       status;
      logic [IDX_W-1:0] buffer_index;
      length_type       out_length;
   } outcome_type;

   class ring_pool_scoreboard;
      logic [IDX_W-1:0]  next_free[POOL_N];
      logic [IDX_W-1:0]  free_head;
      logic [IDX_W-1:0]  free_tail;
      logic [IDX_W-1:0]  slot_buffer[RING_N];
      length_type        slot_length[RING_N];
      logic [SLOT_W-1:0] read_slot;
      logic [SLOT_W-1:0] write_slot;
      outcome_type       outcome_q[$];
      int                errors;
      int                status_seen[5];

      function new();
         for (int i = 0; i < POOL_N; i++) next_free[i] = IDX_W'(i + 1);
         for (int i = 0; i < RING_N; i++) begin
            slot_buffer[i] = '0;
            slot_length[i] = '0;
         end
         free_head  = '0;
         free_tail  = IDX_W'(POOL_N - 1);
         read_slot  = '0;
         write_slot = '0;
         errors     = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      // Work out the response to an accepted command and queue it.
      function void note_command(command_type cmd, length_type len);
         outcome_type      expected;
         logic [IDX_W-1:0] taken_id;
         expected = '{STATUS_OK, '0, '0};
         if (cmd == CMD_PRODUCE) begin
            if (len > BUFFER_BYTES) begin
               expected.status = STATUS_TOO_LONG;
            end else if (SLOT_W'(write_slot + 1) == read_slot) begin
               expected.status = STATUS_RING_FULL;
            end else if (free_head == free_tail) begin
               expected.status = STATUS_POOL_EXHAUSTED;
            end else begin
               taken_id = free_head;
               free_head = next_free[taken_id];
               slot_buffer[write_slot] = taken_id;
               slot_length[write_slot] = len;
               write_slot = SLOT_W'(write_slot + 1);
               expected.buffer_index = taken_id;
            end
         end else begin
            if (read_slot == write_slot) begin
               expected.status = STATUS_RING_EMPTY;
            end else begin
               taken_id = slot_buffer[read_slot];
               expected.buffer_index = taken_id;
               expected.out_length = slot_length[read_slot];
               read_slot = SLOT_W'(read_slot + 1);
               next_free[free_tail] = taken_id;
               free_tail = taken_id;
            end
         end
         status_seen[int'(expected.status)]++;
         outcome_q.push_back(expected);
      endfunction

      function void check_result(status_type st, logic [IDX_W-1:0] idx, length_type len);
         outcome_type expected;
         if (outcome_q.size() == 0) begin
            $error("response beat with no command outstanding");
            errors++;
            return;
         end
         expected = outcome_q.pop_front();
         if (st !== expected.status) begin
            $error("status mismatch: expected %0d, actual %0d", expected.status, st);
            errors++;
         end
         if (idx !== expected.buffer_index) begin
            $error("buffer_index mismatch: expected %0d, actual %0d",
                   expected.buffer_index, idx);
            errors++;
         end
         if (len !== expected.out_length) begin
            $error("out_length mismatch: expected %0d, actual %0d", expected.out_length, len);
            errors++;
         end
      endfunction

      function int outstanding();
         return outcome_q.size();
      endfunction
   endclass
endpackage

module tb;
   import bprd_pkg::*;
   import bprd_tb_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int LONG_HOLD   = 300;
   localparam int RANDOM_CMDS = 800;

   logic clock;
   logic reset;
   int   quiet_cycles = 0;
   int   send_gap_max = 18;
   int   take_gap_max = 18;
   bit   hold_request = 0;

   ring_pool_scoreboard pool_sb = new();

   bprd_req_if req_if();
   bprd_rsp_if rsp_if();

   buffer_pool_with_descriptor_ring dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.command    <= CMD_PRODUCE;
      req_if.msg_length <= '0;
      rsp_if.ready      <= 1'b0;
   end

   // Called in the step of a rising edge; leaves valid high after the beat.
   task automatic send_command(command_type cmd, length_type len);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.command    <= cmd;
      req_if.msg_length <= len;
      do @(posedge clock); while (!req_if.ready);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready)
            pool_sb.check_result(rsp_if.status, rsp_if.buffer_index, rsp_if.out_length);
         if (req_if.valid && req_if.ready)
            pool_sb.note_command(req_if.command, req_if.msg_length);
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $error("watchdog: no beat for %0d cycles, %0d responses outstanding",
                quiet_cycles, pool_sb.outstanding());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Response side: random stalls, quiet stretches, one long hold-off.
   initial begin
      int gap;
      int taken;
      taken = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (taken % 40 == 0) take_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 18;
         gap = $urandom_range(0, take_gap_max);
         if (hold_request) begin
            gap = LONG_HOLD;
            hold_request = 0;
         end
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         taken++;
      end
   end

   initial begin
      int produce_pct;
      length_type len;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty ring, oversize lengths, fill to full, partial drain
      send_command(CMD_CONSUME, 5'd0);
      send_command(CMD_PRODUCE, 5'd17);
      send_command(CMD_PRODUCE, 5'd31);
      for (int i = 0; i < RING_N - 1; i++) begin
         if (i == 0) len = 5'd0;
         else if (i == 1) len = 5'd16;
         else len = length_type'($urandom_range(0, BUFFER_BYTES));
         send_command(CMD_PRODUCE, len);
      end
      send_command(CMD_PRODUCE, 5'd16);
      repeat (5) send_command(CMD_CONSUME, 5'd31);

      produce_pct = 50;
      for (int n = 0; n < RANDOM_CMDS; n++) begin
         if (n % 50 == 0) begin
            produce_pct  = $urandom_range(15, 85);
            send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 18;
         end
         if (n == 400) begin
            hold_request = 1;
            send_gap_max = 0;
         end
         if ($urandom_range(0, 99) < produce_pct) begin
            if ($urandom_range(0, 9) == 0) len = length_type'($urandom_range(17, 31));
            else len = length_type'($urandom_range(0, BUFFER_BYTES));
            send_command(CMD_PRODUCE, len);
         end else begin
            send_command(CMD_CONSUME, length_type'($urandom_range(0, 31)));
         end
      end
      req_if.valid <= 1'b0;

      while (pool_sb.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Run summary: ok %0d, ring full %0d, pool exhausted %0d, ring empty %0d,",
               pool_sb.status_seen[STATUS_OK], pool_sb.status_seen[STATUS_RING_FULL],
               pool_sb.status_seen[STATUS_POOL_EXHAUSTED],
               pool_sb.status_seen[STATUS_RING_EMPTY]);
      $display("  too long %0d; one %0d-cycle response hold-off with commands still offered",
               pool_sb.status_seen[STATUS_TOO_LONG], LONG_HOLD);
      if (pool_sb.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
